FILE: rtl/m3i_pkg.sv
// Shared types, constants and helper functions for the 3x3 matrix unit.
package m3i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EW        = 32;                // element width
  localparam int PW        = 2 * EW;            // element product width
  localparam int MW        = PW + 1;            // exact 2x2 minor width
  localparam int TW        = EW + MW - 1;       // element times minor width
  localparam int DW        = TW + 2;            // exact determinant width
  localparam int XW        = DW + 2;            // working width for round and saturate
  localparam int NW        = MW + 2 * FRAC_BITS; // dividend width
  localparam int RW        = DW + 1;            // partial remainder width
  localparam int QW        = 34;                // kept quotient bits
  localparam int CW        = $clog2(NW + 1);
  localparam int QDEPTH    = 4;
  localparam int LW        = 31;                // singular limit width

  typedef enum logic [1:0] {
    ACT_DET = 2'd0,
    ACT_ADJ = 2'd1,
    ACT_INV = 2'd2,
    ACT_TRN = 2'd3
  } action_e;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [MW-1:0] minor_t;
  typedef logic signed [DW-1:0] det_t;

  // Work handed from the front to the back
  typedef struct packed {
    action_e           action;
    elem_t [8:0]       e;
    minor_t [8:0]      mn;
    logic [DW-1:0]     dmag;
    logic              det_neg;
    elem_t             det_value;
    logic              det_ovf;
    logic              sing;
  } qent_t;

  // One result beat
  typedef struct packed {
    elem_t [8:0] r;
    elem_t       det_value;
    logic        singular;
    logic        overflow;
  } res_t;

  // Element index used by term j of adjugate entry k: e[p]*e[q] - e[r]*e[s]
  function automatic logic [3:0] minor_idx(input int k, input int j);
    logic [15:0] row;
    unique case (k)
      0:       row = {4'd4, 4'd8, 4'd5, 4'd7};
      1:       row = {4'd2, 4'd7, 4'd1, 4'd8};
      2:       row = {4'd1, 4'd5, 4'd2, 4'd4};
      3:       row = {4'd5, 4'd6, 4'd3, 4'd8};
      4:       row = {4'd0, 4'd8, 4'd2, 4'd6};
      5:       row = {4'd2, 4'd3, 4'd0, 4'd5};
      6:       row = {4'd3, 4'd7, 4'd4, 4'd6};
      7:       row = {4'd1, 4'd6, 4'd0, 4'd7};
      default: row = {4'd0, 4'd4, 4'd1, 4'd3};
    endcase
    return row[15-4*j -: 4];
  endfunction

  // Saturate a wide signed value to an element; top bit of the result is the flag
  function automatic logic [EW:0] sat_elem(input logic signed [XW-1:0] v);
    logic [XW-EW:0] top;
    top = v[XW-1:EW-1];
    if ((top == '0) || (top == '1)) begin
      return {1'b0, v[EW-1:0]};
    end
    return v[XW-1] ? {1'b1, 1'b1, {(EW-1){1'b0}}} : {1'b1, 1'b0, {(EW-1){1'b1}}};
  endfunction

  // Drop s fraction bits, rounding to nearest with ties toward +infinity
  function automatic logic [EW:0] round_sat(input logic signed [XW-1:0] v, input int s);
    logic signed [XW-1:0] t;
    t = v + (XW'(1) << (s - 1));
    return sat_elem(t >>> s);
  endfunction

endpackage

FILE: rtl/m3i_if.sv
// Stream channel interfaces for matrix items and result items.
interface m3i_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic signed [31:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, action, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, action, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface m3i_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [31:0]  det_value;
  logic                singular;
  logic                overflow;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  det_value, singular, overflow, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  det_value, singular, overflow, output ready);
endinterface

FILE: rtl/m3i_front.sv
// Front pipeline: minors, determinant and classification, one matrix per cycle unless stalled.
module m3i_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  m3i_pkg::action_e      in_action_i,
  input  m3i_pkg::elem_t [8:0]  in_e_i,
  input  logic [m3i_pkg::LW-1:0] limit_i,
  input  logic                  full_i,
  output logic                  push_o,
  output m3i_pkg::qent_t        ent_o
);
  import m3i_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  action_e act1_q, act2_q, act3_q, act4_q, act5_q, act6_q;
  elem_t [8:0] e1_q, e2_q, e3_q, e4_q, e5_q, e6_q;
  logic signed [PW-1:0] pa2_q [9];
  logic signed [PW-1:0] pb2_q [9];
  minor_t [8:0] mn3_q, mn4_q, mn5_q, mn6_q;
  logic signed [MW-1:0] plo4_q [3];
  logic signed [MW-1:0] phi4_q [3];
  logic signed [TW-1:0] term5_q [3];
  det_t det6_q;
  qent_t ent7_q;

  // whole pipe holds while the last stage cannot hand over
  assign en         = !(v7_q && full_i);
  assign in_ready_o = en;
  assign push_o     = v7_q && !full_i;
  assign ent_o      = ent7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
    end
  end

  // stage logic
  logic signed [PW-1:0] pa_d [9];
  logic signed [PW-1:0] pb_d [9];
  minor_t [8:0]         mn_d;
  logic signed [MW-1:0] plo_d [3];
  logic signed [MW-1:0] phi_d [3];
  logic signed [TW-1:0] term_d [3];
  det_t                 det_d;
  qent_t                ent_d;
  logic [EW:0]          dsat;
  logic [DW-1:0]        lim;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pa_d[k] = PW'(e1_q[minor_idx(k, 0)]) * PW'(e1_q[minor_idx(k, 1)]);
      pb_d[k] = PW'(e1_q[minor_idx(k, 2)]) * PW'(e1_q[minor_idx(k, 3)]);
      mn_d[k] = MW'(pa2_q[k]) - MW'(pb2_q[k]);
    end
    for (int j = 0; j < 3; j++) begin
      plo_d[j]  = MW'(e3_q[j]) * MW'($signed({1'b0, mn3_q[3*j][EW-1:0]}));
      phi_d[j]  = MW'(e3_q[j]) * MW'($signed(mn3_q[3*j][MW-1:EW]));
      term_d[j] = (TW'(phi4_q[j]) <<< EW) + TW'(plo4_q[j]);
    end
    det_d = DW'(term5_q[0]) + DW'(term5_q[1]) + DW'(term5_q[2]);

    // classify
    dsat          = round_sat(XW'(det6_q), 2 * FRAC_BITS);
    lim           = DW'(limit_i) << (2 * FRAC_BITS);
    ent_d.action  = act6_q;
    ent_d.e       = e6_q;
    ent_d.mn      = mn6_q;
    ent_d.det_neg = det6_q[DW-1];
    ent_d.dmag    = det6_q[DW-1] ? DW'(-det6_q) : DW'(det6_q);
    ent_d.det_value = dsat[EW-1:0];
    ent_d.det_ovf = dsat[EW];
    ent_d.sing    = (ent_d.dmag < lim) || (det6_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q <= in_action_i; e1_q <= in_e_i;
      act2_q <= act1_q; e2_q <= e1_q;
      for (int k = 0; k < 9; k++) begin
        pa2_q[k] <= pa_d[k];
        pb2_q[k] <= pb_d[k];
      end
      act3_q <= act2_q; e3_q <= e2_q; mn3_q <= mn_d;
      act4_q <= act3_q; e4_q <= e3_q; mn4_q <= mn3_q;
      for (int j = 0; j < 3; j++) begin
        plo4_q[j]  <= plo_d[j];
        phi4_q[j]  <= phi_d[j];
        term5_q[j] <= term_d[j];
      end
      act5_q <= act4_q; e5_q <= e4_q; mn5_q <= mn4_q;
      act6_q <= act5_q; e6_q <= e5_q; mn6_q <= mn5_q; det6_q <= det_d;
      ent7_q <= ent_d;
    end
  end

endmodule

FILE: rtl/m3i_fifo.sv
// Short queue of classified items between front and back.
module m3i_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  m3i_pkg::qent_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output m3i_pkg::qent_t data_o
);
  import m3i_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  qent_t          mem_q [QDEPTH];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

FILE: rtl/m3i_back.sv
// Back end: result forming and a nine-lane bit-serial divider for inverse.
module m3i_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  m3i_pkg::qent_t ent_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output m3i_pkg::res_t  out_o
);
  import m3i_pkg::*;

  logic            busy_q;
  logic [CW-1:0]   cnt_q;
  logic [NW-1:0]   num_q [9];
  logic [RW-1:0]   rem_q [9];
  logic [QW-1:0]   quo_q [9];
  logic [8:0]      stk_q, neg_q;
  logic [DW-1:0]   dmag_q;
  elem_t           dval_q;
  logic            dovf_q;
  logic            oval_q;
  res_t            res_q;

  logic            out_free, is_div, take_div, take_dir, done;
  res_t            dir_res, div_res;
  logic [RW-1:0]   rs [9];
  logic [8:0]      ge;
  logic [MW-1:0]   nmag [9];
  logic [QW:0]     qf;
  logic [EW:0]     asat;

  assign out_free    = !oval_q || out_ready_i;
  assign is_div      = (ent_i.action == ACT_INV) && !ent_i.sing;
  assign take_div    = !busy_q && !empty_i && is_div;
  assign take_dir    = !busy_q && !empty_i && !is_div && out_free;
  assign done        = busy_q && (cnt_q == CW'(NW)) && out_free;
  assign pop_o       = take_div || take_dir;
  assign out_valid_o = oval_q;
  assign out_o       = res_q;

  // direct results and divider steps
  always_comb begin
    dir_res.det_value = ent_i.det_value;
    dir_res.singular  = ent_i.sing;
    dir_res.overflow  = ent_i.det_ovf;
    for (int k = 0; k < 9; k++) begin
      asat = round_sat(XW'(ent_i.mn[k]), FRAC_BITS);
      unique case (ent_i.action)
        ACT_ADJ: begin
          dir_res.r[k] = asat[EW-1:0];
          if (asat[EW]) dir_res.overflow = 1'b1;
        end
        ACT_TRN: dir_res.r[k] = ent_i.e[3*(k%3) + k/3];
        default: dir_res.r[k] = '0;
      endcase
      nmag[k] = ent_i.mn[k][MW-1] ? MW'(-ent_i.mn[k]) : MW'(ent_i.mn[k]);
      rs[k]   = {rem_q[k][RW-2:0], num_q[k][NW-1]};
      ge[k]   = (rs[k] >= {1'b0, dmag_q});
    end

    div_res.det_value = dval_q;
    div_res.singular  = 1'b0;
    div_res.overflow  = dovf_q;
    for (int k = 0; k < 9; k++) begin
      qf = (QW+1)'(quo_q[k]) +
           (QW+1)'({rem_q[k][RW-2:0], 1'b0} >= {1'b0, dmag_q});
      if (stk_q[k] || (neg_q[k] ? (qf > (QW+1)'(33'h080000000))
                                : (qf >= (QW+1)'(33'h080000000)))) begin
        div_res.r[k]     = neg_q[k] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        div_res.overflow = 1'b1;
      end else begin
        div_res.r[k] = neg_q[k] ? -qf[EW-1:0] : qf[EW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (take_div) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q && (cnt_q != CW'(NW))) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (take_dir || done)  oval_q <= 1'b1;
      else if (out_ready_i)  oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_dir)  res_q <= dir_res;
    else if (done) res_q <= div_res;
    if (take_div) begin
      dmag_q <= ent_i.dmag;
      dval_q <= ent_i.det_value;
      dovf_q <= ent_i.det_ovf;
      for (int k = 0; k < 9; k++) begin
        num_q[k] <= NW'(nmag[k]) << (2 * FRAC_BITS);
        rem_q[k] <= '0;
        quo_q[k] <= '0;
        stk_q[k] <= 1'b0;
        neg_q[k] <= ent_i.mn[k][MW-1] ^ ent_i.det_neg;
      end
    end else if (busy_q && (cnt_q != CW'(NW))) begin
      for (int k = 0; k < 9; k++) begin
        num_q[k] <= {num_q[k][NW-2:0], 1'b0};
        rem_q[k] <= ge[k] ? rs[k] - {1'b0, dmag_q} : rs[k];
        quo_q[k] <= {quo_q[k][QW-2:0], ge[k]};
        stk_q[k] <= stk_q[k] | quo_q[k][QW-1];
      end
    end
  end

endmodule

FILE: rtl/mat3_inverse_unit.sv
// 3x3 matrix determinant, adjugate, inverse and transpose unit (top level).
// A seven-stage front pipeline takes one matrix per cycle and works out the
// exact minors, the determinant and the singular flag; a four-entry queue
// feeds the back end. Determinant, adjugate, transpose and singular inverse
// beats leave the back end one per cycle while the output is accepted.
// A non-singular inverse runs all nine elements through a bit-serial divider
// with one quotient bit per cycle and gives Q16.16 results; it holds the
// back end from its pop until its result is taken, and the front stalls
// once the queue is full. singular_limit sits at address 0 and resets to 1.
module mat3_inverse_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  m3i_in_if.sink       in_i,
  m3i_out_if.source    out_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);
  import m3i_pkg::*;

  logic [LW-1:0] limit_q;
  elem_t [8:0]   in_e;
  qent_t         f_ent, q_ent;
  logic          push, full, pop, empty;
  res_t          res;

  // configuration register, word address taken from paddr bit 2
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == 1'b0) ? {1'b0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LW'(1);
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == 1'b0)) begin
      limit_q <= pwdata_i[LW-1:0];
    end
  end

  assign in_e = {in_i.m22, in_i.m21, in_i.m20, in_i.m12, in_i.m11, in_i.m10,
                 in_i.m02, in_i.m01, in_i.m00};

  m3i_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_action_i (action_e'(in_i.action)),
    .in_e_i      (in_e),
    .limit_i     (limit_q),
    .full_i      (full),
    .push_o      (push),
    .ent_o       (f_ent)
  );

  m3i_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (f_ent),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_ent)
  );

  m3i_back u_back (
    .clk_i, .rst_ni,
    .empty_i     (empty),
    .ent_i       (q_ent),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.r00 = res.r[0]; assign out_o.r01 = res.r[1]; assign out_o.r02 = res.r[2];
  assign out_o.r10 = res.r[3]; assign out_o.r11 = res.r[4]; assign out_o.r12 = res.r[5];
  assign out_o.r20 = res.r[6]; assign out_o.r21 = res.r[7]; assign out_o.r22 = res.r[8];
  assign out_o.det_value = res.det_value;
  assign out_o.singular  = res.singular;
  assign out_o.overflow  = res.overflow;

endmodule
